// File: sv/qcv_pkg.sv
// ----------------------------------------------------------------------------
// qcv_pkg
// Shared types and codes for the quantized change-of-value filter.
// ----------------------------------------------------------------------------
package qcv_pkg;

  localparam int KEY_W  = 22;
  localparam int TC_W   = 4;
  localparam int VAL_W  = 32;
  localparam int QUO_W  = 34;

  // value type codes
  localparam logic [1:0] VT_NONE   = 2'd0;
  localparam logic [1:0] VT_INT    = 2'd1;
  localparam logic [1:0] VT_FLOAT  = 2'd2;
  localparam logic [1:0] VT_STRING = 2'd3;

  // source and destination group codes
  localparam logic [1:0] GRP_A     = 2'd0;
  localparam logic [1:0] GRP_B     = 2'd1;
  localparam logic [1:0] DST_NONE  = 2'd0;
  localparam logic [1:0] DST_B     = 2'd1;
  localparam logic [1:0] DST_A     = 2'd2;

  localparam logic [31:0] STEP_RESET = 32'd66;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [TC_W-1:0]  tc_t;

  // handshake between sequencer and divider
  typedef struct packed {
    logic        start;
    logic [31:0] raw;
    logic [31:0] step;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic             neg;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

// File: sv/qcv_in_if.sv
// ----------------------------------------------------------------------------
// qcv_in_if
// Message channel: valid/ready plus message fields.
// ----------------------------------------------------------------------------
interface qcv_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         source_group;
  logic [9:0]         object_id;
  logic [6:0]         channel;
  logic [4:0]         record;
  logic [1:0]         value_type;
  logic [1:0]         value_count;
  logic signed [31:0] value_a;
  logic signed [31:0] value_b;
  logic signed [31:0] value_c;

  modport source (output valid, source_group, object_id, channel, record,
                  value_type, value_count, value_a, value_b, value_c,
                  input ready);
  modport sink   (input valid, source_group, object_id, channel, record,
                  value_type, value_count, value_a, value_b, value_c,
                  output ready);
endinterface

// File: sv/qcv_out_if.sv
// ----------------------------------------------------------------------------
// qcv_out_if
// Result channel: valid/ready plus filter decision.
// ----------------------------------------------------------------------------
interface qcv_out_if;
  logic       valid;
  logic       ready;
  logic       forward;
  logic [1:0] destination_group;
  logic       changed;
  logic       table_full;

  modport source (output valid, forward, destination_group, changed, table_full,
                  input ready);
  modport sink   (input valid, forward, destination_group, changed, table_full,
                  output ready);
endinterface

// File: sv/quantized_change_of_value_filter_unit.sv
// ----------------------------------------------------------------------------
// quantized_change_of_value_filter_unit
// Change-of-value filter with a last-value table and quantized float compare.
// ----------------------------------------------------------------------------
// Sequence: the scan reads each table entry up to the hit (every stored entry
//   on a miss), then compares each integer value directly and each float value
//   by two 34-bit serial divides, then writes the key and each value, then the result.
// Throughput: one message at a time; the scan and the shared divider set it.
// Reset: synchronous active-low; table empty (fill count 0), step = 66.
// ----------------------------------------------------------------------------
module quantized_change_of_value_filter_unit #(
  parameter int TABLE_ENTRIES = 64,
  parameter int MAX_VALUES    = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  qcv_in_if.sink      in_bus,
  qcv_out_if.source   out_bus,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import qcv_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int FC_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int VDEP  = TABLE_ENTRIES * MAX_VALUES;
  localparam int VA_W  = (VDEP > 1) ? $clog2(VDEP) : 1;
  localparam int NV    = (MAX_VALUES < 3) ? MAX_VALUES : 3;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_KRD  = 4'd1;
  localparam logic [3:0] S_KCMP = 4'd2;
  localparam logic [3:0] S_VRD  = 4'd3;
  localparam logic [3:0] S_VCMP = 4'd4;
  localparam logic [3:0] S_DOLD = 4'd5;
  localparam logic [3:0] S_DNEW = 4'd6;
  localparam logic [3:0] S_WKEY = 4'd7;
  localparam logic [3:0] S_WVAL = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  // table storage
  logic [KEY_W+TC_W-1:0] kmem [TABLE_ENTRIES];
  logic [VAL_W-1:0]      vmem [VDEP];
  logic [KEY_W+TC_W-1:0] krd_r;
  logic [VAL_W-1:0]      vrd_r;

  logic [3:0]       state_r, state_nxt;
  logic [31:0]      step_r;
  logic [FC_W-1:0]  fill_r, fill_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic [VA_W-1:0]  base_r, base_nxt;
  logic [1:0]       k_r, k_nxt;
  logic             hit_r, hit_nxt;
  logic             chg_r, chg_nxt;
  logic             full_r, full_nxt;
  logic             qo_neg_r, qo_neg_nxt;
  logic [QUO_W-1:0] qo_r, qo_nxt;

  // latched message
  logic [1:0]       grp_r;
  key_t             key_r;
  logic [1:0]       vt_r;
  logic [1:0]       vc_r;
  logic [1:0]       n_r;
  logic [VAL_W-1:0] vals_r [3];

  logic             ov_r, ov_nxt;
  logic             o_fwd_r, o_fwd_nxt;
  logic [1:0]       o_dst_r, o_dst_nxt;
  logic             o_chg_r, o_chg_nxt;
  logic             o_full_r, o_full_nxt;

  div_req_t         dreq;
  div_rsp_t         drsp;

  logic             in_acc;
  logic             k_we, v_we;
  logic [VA_W-1:0]  vaddr;
  logic [VAL_W-1:0] cur_val;
  logic [2:0]       k_inc;
  logic             k_last;
  logic             q_differ;
  logic [1:0]       n_in;

  qcv_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign in_bus.ready = (state_r == S_IDLE);
  assign in_acc       = in_bus.valid && in_bus.ready;

  assign cur_val = vals_r[k_r];
  assign k_inc   = {1'b0, k_r} + 3'd1;
  assign k_last  = (k_inc == {1'b0, n_r});
  assign vaddr   = base_r + VA_W'(k_r);
  assign n_in    = (in_bus.value_count > 2'(NV)) ? 2'(NV) : in_bus.value_count;

  // zero quotients compare equal regardless of sign
  assign q_differ = (qo_r != drsp.quo) ||
                    ((qo_r != '0) && (qo_neg_r != drsp.neg));

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    idx_nxt    = idx_r;
    slot_nxt   = slot_r;
    base_nxt   = base_r;
    k_nxt      = k_r;
    hit_nxt    = hit_r;
    chg_nxt    = chg_r;
    full_nxt   = full_r;
    qo_neg_nxt = qo_neg_r;
    qo_nxt     = qo_r;
    ov_nxt     = ov_r;
    o_fwd_nxt  = o_fwd_r;
    o_dst_nxt  = o_dst_r;
    o_chg_nxt  = o_chg_r;
    o_full_nxt = o_full_r;
    dreq.start = 1'b0;
    dreq.raw   = vrd_r;
    dreq.step  = step_r;
    k_we       = 1'b0;
    v_we       = 1'b0;

    if (ov_r && out_bus.ready) ov_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          chg_nxt  = 1'b0;
          full_nxt = 1'b0;
          hit_nxt  = 1'b0;
          idx_nxt  = '0;
          k_nxt    = '0;
          if (step_r == '0) begin
            chg_nxt   = 1'b1;
            state_nxt = S_DONE;
          end else if (fill_r == '0) begin
            // empty table: straight to the miss path
            chg_nxt   = 1'b1;
            slot_nxt  = '0;
            base_nxt  = '0;
            state_nxt = S_WKEY;
          end else begin
            state_nxt = S_KRD;
          end
        end
      end
      S_KRD: state_nxt = S_KCMP;
      S_KCMP: begin
        if (krd_r[KEY_W+TC_W-1:TC_W] == key_r) begin
          hit_nxt  = 1'b1;
          slot_nxt = idx_r;
          base_nxt = VA_W'(idx_r) * VA_W'(MAX_VALUES);
          if (krd_r[TC_W-1:0] != {vt_r, vc_r}) begin
            chg_nxt   = 1'b1;
            state_nxt = S_WKEY;
          end else if ((vt_r == VT_INT || vt_r == VT_FLOAT) && n_r != '0) begin
            state_nxt = S_VRD;
          end else if ((vt_r == VT_NONE || vt_r == VT_STRING) && vc_r != '0) begin
            chg_nxt   = 1'b1;
            state_nxt = S_WKEY;
          end else begin
            state_nxt = S_DONE;
          end
        end else if ((FC_W'(idx_r) + FC_W'(1)) == fill_r) begin
          chg_nxt = 1'b1;
          if (fill_r == FC_W'(TABLE_ENTRIES)) begin
            full_nxt  = 1'b1;
            state_nxt = S_DONE;
          end else begin
            slot_nxt  = IDX_W'(fill_r);
            base_nxt  = VA_W'(fill_r) * VA_W'(MAX_VALUES);
            state_nxt = S_WKEY;
          end
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_KRD;
        end
      end
      S_VRD: state_nxt = S_VCMP;
      S_VCMP: begin
        if (vt_r == VT_INT) begin
          if (vrd_r != cur_val) begin
            chg_nxt   = 1'b1;
            k_nxt     = '0;
            state_nxt = S_WKEY;
          end else if (k_last) begin
            state_nxt = S_DONE;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = S_VRD;
          end
        end else begin
          dreq.start = 1'b1;
          dreq.raw   = vrd_r;
          state_nxt  = S_DOLD;
        end
      end
      S_DOLD: begin
        if (drsp.done) begin
          qo_nxt     = drsp.quo;
          qo_neg_nxt = drsp.neg;
          dreq.start = 1'b1;
          dreq.raw   = cur_val;
          state_nxt  = S_DNEW;
        end
      end
      S_DNEW: begin
        if (drsp.done) begin
          if (q_differ) begin
            chg_nxt   = 1'b1;
            k_nxt     = '0;
            state_nxt = S_WKEY;
          end else if (k_last) begin
            state_nxt = S_DONE;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = S_VRD;
          end
        end
      end
      S_WKEY: begin
        k_we  = 1'b1;
        k_nxt = '0;
        if (!hit_r) fill_nxt = fill_r + FC_W'(1);
        state_nxt = (n_r != '0) ? S_WVAL : S_DONE;
      end
      S_WVAL: begin
        v_we = 1'b1;
        if (k_last) begin
          state_nxt = S_DONE;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      S_DONE: begin
        if (!ov_r || out_bus.ready) begin
          ov_nxt     = 1'b1;
          o_chg_nxt  = chg_r;
          o_full_nxt = full_r;
          o_fwd_nxt  = chg_r && (grp_r == GRP_A || grp_r == GRP_B);
          o_dst_nxt  = !chg_r          ? DST_NONE :
                       (grp_r == GRP_A) ? DST_B :
                       (grp_r == GRP_B) ? DST_A : DST_NONE;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      step_r  <= STEP_RESET;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) step_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    slot_r   <= slot_nxt;
    base_r   <= base_nxt;
    k_r      <= k_nxt;
    hit_r    <= hit_nxt;
    chg_r    <= chg_nxt;
    full_r   <= full_nxt;
    qo_r     <= qo_nxt;
    qo_neg_r <= qo_neg_nxt;
    o_fwd_r  <= o_fwd_nxt;
    o_dst_r  <= o_dst_nxt;
    o_chg_r  <= o_chg_nxt;
    o_full_r <= o_full_nxt;
    if (in_acc) begin
      grp_r     <= in_bus.source_group;
      key_r     <= {in_bus.object_id, in_bus.channel, in_bus.record};
      vt_r      <= in_bus.value_type;
      vc_r      <= in_bus.value_count;
      n_r       <= n_in;
      vals_r[0] <= in_bus.value_a;
      vals_r[1] <= in_bus.value_b;
      vals_r[2] <= in_bus.value_c;
    end
  end

  // key / type-count memory
  always_ff @(posedge clk) begin
    if (k_we) kmem[slot_r] <= {key_r, vt_r, vc_r};
    krd_r <= kmem[idx_r];
  end

  // value memory
  always_ff @(posedge clk) begin
    if (v_we) vmem[vaddr] <= cur_val;
    vrd_r <= vmem[vaddr];
  end

  assign out_bus.valid             = ov_r;
  assign out_bus.forward           = o_fwd_r;
  assign out_bus.destination_group = o_dst_r;
  assign out_bus.changed           = o_chg_r;
  assign out_bus.table_full        = o_full_r;

endmodule

// File: sv/qcv_div.sv
// ----------------------------------------------------------------------------
// qcv_div
// Bit-serial restoring divider: round(raw / step) half away from zero,
// as (2*|raw| + step) / (2*step), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qcv_div (
  input  logic              clk,
  input  logic              rst_n,
  input  qcv_pkg::div_req_t req,
  output qcv_pkg::div_rsp_t rsp
);
  import qcv_pkg::*;

  logic [QUO_W-1:0] num_r, num_nxt;
  logic [QUO_W:0]   rem_r, rem_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [32:0]      den_r, den_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             neg_r, neg_nxt;

  logic [31:0]      mag;
  logic [QUO_W:0]   rem_sh;
  logic [QUO_W+1:0] diff;

  always_comb begin
    mag    = req.raw[31] ? (~req.raw + 32'd1) : req.raw;
    rem_sh = {rem_r[QUO_W-1:0], num_r[QUO_W-1]};
    diff   = {1'b0, rem_sh} - {3'b000, den_r};
  end

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    if (req.start) begin
      // most negative raw gives mag 0x80000000, which the negate already yields
      num_nxt  = {1'b0, mag, 1'b0} + {2'b00, req.step};
      den_nxt  = {req.step, 1'b0};
      rem_nxt  = '0;
      quo_nxt  = '0;
      cnt_nxt  = 6'(QUO_W);
      neg_nxt  = req.raw[31];
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[QUO_W-2:0], 1'b0};
      if (!diff[QUO_W+1]) begin
        rem_nxt = diff[QUO_W:0];
        quo_nxt = {quo_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[QUO_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.neg  = neg_r;
  assign rsp.quo  = quo_r;

endmodule

// File: sv/qcv_chk.sv
// ----------------------------------------------------------------------------
// qcv_chk
// Port-level checks for the change-of-value filter, bound to the top level.
// ----------------------------------------------------------------------------
module qcv_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_forward,
  input logic [1:0] out_destination_group,
  input logic       out_changed,
  input logic       out_table_full
);
  import qcv_pkg::*;

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_forward, out_destination_group, out_changed, out_table_full}))
    else $error("result beat changed while stalled");

  // block is busy right after taking a message
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

  // forwarding only for changed messages, with a real destination
  a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_forward |->
      out_changed && (out_destination_group == DST_A || out_destination_group == DST_B))
    else $error("forward without change or destination");

  // a full table only reports on a changed message
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |-> out_changed)
    else $error("table_full without change");

endmodule

bind quantized_change_of_value_filter_unit qcv_chk u_qcv_chk (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_bus.valid),
  .in_ready              (in_bus.ready),
  .out_valid             (out_bus.valid),
  .out_ready             (out_bus.ready),
  .out_forward           (out_bus.forward),
  .out_destination_group (out_bus.destination_group),
  .out_changed           (out_bus.changed),
  .out_table_full        (out_bus.table_full)
);

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the quantized change-of-value filter: directed table
// of messages, then random traffic mostly over the stored keys, checked beat by beat.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qcv_pkg::*;

  localparam int ENTRIES = 64;
  localparam int NVAL    = 3;
  localparam int RANDOM_ITEMS = 1600;
  localparam int CYCLE_LIMIT  = 2000000;

  typedef struct packed {
    logic [1:0]  grp;
    logic [9:0]  oid;
    logic [6:0]  chan;
    logic [4:0]  rec;
    logic [1:0]  vtype;
    logic [1:0]  vcount;
    logic [31:0] va;
    logic [31:0] vb;
    logic [31:0] vc;
  } msg_t;

  typedef struct packed {
    logic       fwd;
    logic [1:0] dst;
    logic       chg;
    logic       full;
  } verdict_t;

  typedef struct {
    msg_t     m;
    logic     known;  // verdict typed in
    verdict_t v;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  qcv_in_if  in_bus();
  qcv_out_if out_bus();

  quantized_change_of_value_filter_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // filter state mirror
  logic [31:0] step_q;
  logic        tbl_valid [ENTRIES];
  logic [21:0] tbl_key   [ENTRIES];
  logic [3:0]  tbl_tc    [ENTRIES];
  logic [31:0] tbl_val   [ENTRIES][NVAL];

  verdict_t verdicts_pending[$];
  int  errors = 0;
  int  cycles = 0;
  bit  idle_on = 1'b1;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
    errors++;
  endtask

  function automatic longint quant(input logic [31:0] raw, input logic [31:0] s);
    longint mag;
    longint q;
    mag = raw[31] ? -longint'($signed(raw)) : longint'(raw);
    q = (2 * mag + longint'(s)) / (2 * longint'(s));
    return raw[31] ? -q : q;
  endfunction

  function automatic verdict_t filter_decide(input msg_t m);
    verdict_t r;
    logic [21:0] key;
    logic [3:0] tc;
    logic [31:0] vals [NVAL];
    int hit, free_i, n;
    logic chg, full;
    key = {m.oid, m.chan, m.rec};
    tc = {m.vtype, m.vcount};
    vals[0] = m.va; vals[1] = m.vb; vals[2] = m.vc;
    n = m.vcount;
    hit = -1; free_i = -1; chg = 1'b0; full = 1'b0;
    if (step_q == 0) begin
      chg = 1'b1;
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (tbl_valid[i]) begin
          if (hit < 0 && tbl_key[i] == key) hit = i;
        end else if (free_i < 0) begin
          free_i = i;
        end
      end
      if (hit < 0) begin
        chg = 1'b1;
        full = (free_i < 0);
      end else if (tbl_tc[hit] != tc) begin
        chg = 1'b1;
      end else if (m.vtype == VT_INT || m.vtype == VT_FLOAT) begin
        for (int k = 0; k < n; k++) begin
          if (m.vtype == VT_INT) begin
            if (tbl_val[hit][k] != vals[k]) chg = 1'b1;
          end else if (quant(tbl_val[hit][k], step_q) != quant(vals[k], step_q)) begin
            chg = 1'b1;
          end
        end
      end else begin
        chg = (m.vcount != 0);
      end
      if (chg) begin
        int slot;
        slot = hit >= 0 ? hit : free_i;
        if (slot >= 0) begin
          tbl_valid[slot] = 1'b1;
          tbl_key[slot] = key;
          tbl_tc[slot] = tc;
          for (int k = 0; k < n; k++) tbl_val[slot][k] = vals[k];
        end
      end
    end
    r = '0;
    r.chg = chg;
    r.full = full;
    if (chg && m.grp == GRP_A) begin
      r.fwd = 1'b1; r.dst = DST_B;
    end
    if (chg && m.grp == GRP_B) begin
      r.fwd = 1'b1; r.dst = DST_A;
    end
    return r;
  endfunction

  function automatic msg_t mk(input logic [1:0] g, input logic [9:0] o, input logic [6:0] c,
                              input logic [4:0] r, input logic [1:0] t, input logic [1:0] n,
                              input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] cc);
    msg_t m;
    m.grp = g; m.oid = o; m.chan = c; m.rec = r; m.vtype = t; m.vcount = n;
    m.va = a; m.vb = b; m.vc = cc;
    return m;
  endfunction

  // ready side of the result channel
  always @(negedge clk) begin
    out_bus.ready <= (idle_on && $urandom_range(0, 99) < 11) ? 1'b0 : 1'b1;
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n) begin
      cycles++;
      if (out_bus.valid && out_bus.ready) begin
        if (verdicts_pending.size() == 0) begin
          report("unexpected beat", 0, 0);
        end else begin
          verdict_t e;
          e = verdicts_pending.pop_front();
          if (out_bus.forward !== e.fwd) report("forward", out_bus.forward, e.fwd);
          if (out_bus.destination_group !== e.dst)
            report("destination_group", out_bus.destination_group, e.dst);
          if (out_bus.changed !== e.chg) report("changed", out_bus.changed, e.chg);
          if (out_bus.table_full !== e.full)
            report("table_full", out_bus.table_full, e.full);
        end
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // valid stays up between back-to-back beats; idle cycles and drain drop it
  task automatic send_msg(input msg_t m, input logic known, input verdict_t v);
    verdict_t e;
    while (idle_on && $urandom_range(0, 99) < 11) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.source_group <= m.grp;
    in_bus.object_id <= m.oid;
    in_bus.channel <= m.chan;
    in_bus.record <= m.rec;
    in_bus.value_type <= m.vtype;
    in_bus.value_count <= m.vcount;
    in_bus.value_a <= m.va;
    in_bus.value_b <= m.vb;
    in_bus.value_c <= m.vc;
    do @(posedge clk); while (!in_bus.ready);
    e = filter_decide(m);
    if (known && e != v) report("typed row", e, v);
    verdicts_pending.push_back(e);
    @(negedge clk);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (verdicts_pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_step(input logic [31:0] s);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= s;
    @(negedge clk);
    cfg_we <= 1'b0;
    step_q = s;
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 200) - 100;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    row_t rows[$];
    msg_t m;
    verdict_t v0;
    logic [31:0] steps [5];
    in_bus.valid = 1'b0;
    in_bus.source_group = '0; in_bus.object_id = '0; in_bus.channel = '0;
    in_bus.record = '0; in_bus.value_type = '0; in_bus.value_count = '0;
    in_bus.value_a = '0; in_bus.value_b = '0; in_bus.value_c = '0;
    out_bus.ready = 1'b1;
    step_q = STEP_RESET;
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // verdict values: {fwd, dst, chg, full}
    rows.push_back('{mk(GRP_A, 0, 0, 0, VT_INT, 3, 32'h7FFFFFFF, 32'h80000000, 0), 1, 5'b10110});
    rows.push_back('{mk(GRP_A, 0, 0, 0, VT_INT, 3, 32'h7FFFFFFF, 32'h80000000, 0), 1, 5'b00000});
    rows.push_back('{mk(GRP_B, 0, 0, 0, VT_INT, 3, 32'h7FFFFFFF, 32'h80000000, 1), 1, 5'b11010});
    rows.push_back('{mk(2'd2, 1023, 127, 31, VT_FLOAT, 2, 32'h80000000, 32'h7FFFFFFF, 0), 1,
                     5'b00010});
    rows.push_back('{mk(2'd3, 1023, 127, 31, VT_FLOAT, 2, 32'h80000001, 32'h7FFFFFFF, 5), 0, '0});
    rows.push_back('{mk(GRP_A, 1023, 127, 31, VT_FLOAT, 2, 32'd33, 32'h7FFFFFFF, 0), 0, '0});
    rows.push_back('{mk(GRP_A, 1023, 127, 31, VT_FLOAT, 2, 32'd32, 32'h7FFFFFFF, 0), 0, '0});
    rows.push_back('{mk(GRP_A, 1023, 127, 31, VT_FLOAT, 2, -32'sd33, 32'h7FFFFFFF, 0), 0, '0});
    rows.push_back('{mk(GRP_A, 5, 1, 2, VT_NONE, 0, 0, 0, 0), 1, 5'b10110});
    rows.push_back('{mk(GRP_A, 5, 1, 2, VT_NONE, 0, 0, 0, 0), 1, 5'b00000});
    rows.push_back('{mk(GRP_A, 6, 1, 2, VT_STRING, 1, 0, 0, 0), 1, 5'b10110});
    rows.push_back('{mk(GRP_B, 6, 1, 2, VT_STRING, 1, 0, 0, 0), 1, 5'b11010});
    rows.push_back('{mk(GRP_A, 6, 1, 2, VT_STRING, 2, 0, 0, 0), 1, 5'b10110});
    rows.push_back('{mk(GRP_A, 6, 1, 2, VT_INT, 0, 1, 2, 3), 1, 5'b10110});
    rows.push_back('{mk(GRP_A, 6, 1, 2, VT_INT, 0, 9, 9, 9), 1, 5'b00000});
    foreach (rows[i]) send_msg(rows[i].m, rows[i].known, rows[i].v);

    // fill the table: misses beyond the last free entry report full
    for (int i = 0; i < ENTRIES + 3; i++) begin
      m = mk(GRP_B, 10'(100 + i), 7'(i), 5'(i), VT_INT, 1, i, 0, 0);
      send_msg(m, 1'b0, v0);
    end
    // a hit on a full table is still stored
    send_msg(mk(GRP_A, 0, 0, 0, VT_INT, 3, 1, 1, 1), 1'b0, v0);

    write_step(32'd0);
    send_msg(mk(GRP_A, 0, 0, 0, VT_INT, 3, 1, 1, 1), 1'b1, 5'b10110);
    send_msg(mk(2'd2, 900, 0, 0, VT_NONE, 0, 0, 0, 0), 1'b1, 5'b00010);

    // random phases with a fresh table would need reset; keep keys mostly
    // in the stored set so the existing entries are hit and compared
    steps[0] = 32'hFFFF_FFFF; steps[1] = 32'd1; steps[2] = STEP_RESET;
    steps[3] = 32'h0001_0000; steps[4] = 32'd0;
    for (int p = 0; p < 5; p++) begin
      write_step(steps[p]);
      idle_on = (p != 2);
      for (int i = 0; i < RANDOM_ITEMS / 5; i++) begin
        if ($urandom_range(0, 9) < 8) begin
          // revisit a stored key with values near the old ones
          int j;
          j = $urandom_range(0, ENTRIES - 1);
          if (!tbl_valid[j]) j = 0;
          m = mk(2'($urandom_range(0, 3)), tbl_key[j][21:12], tbl_key[j][11:5],
                 tbl_key[j][4:0], tbl_tc[j][3:2], tbl_tc[j][1:0],
                 tbl_val[j][0], tbl_val[j][1], tbl_val[j][2]);
          if ($urandom_range(0, 2) == 0) m.va = m.va + $urandom_range(0, 4) - 2;
          if ($urandom_range(0, 4) == 0) m.vb = rand_val();
          if ($urandom_range(0, 9) == 0) m.vtype = 2'($urandom_range(0, 3));
          if ($urandom_range(0, 9) == 0) m.vcount = 2'($urandom_range(0, 3));
        end else begin
          m = mk(2'($urandom_range(0, 3)), 10'($urandom_range(0, 1023)),
                 7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)),
                 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                 rand_val(), rand_val(), rand_val());
        end
        send_msg(m, 1'b0, v0);
        if (i == 50) drain();
      end
    end
    idle_on = 1'b1;
    drain();
    repeat (300) @(negedge clk);
    if (errors == 0 && verdicts_pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
